// File: sv/dpsfl_pkg.sv
// Shared constants and types of the dual-plane slot free list.
`timescale 1ns / 1ps
`default_nettype none
package dpsfl_pkg;

    localparam int SLOT_COUNT = 1024;
    localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int ADDR_W     = SLOT_W + 1;
    localparam int LINK_DEPTH = 2 ** ADDR_W;
    localparam int FIELD_W    = 10;
    localparam int STATUS_W   = 2;
    localparam int COUNT_W    = 32;

    localparam logic OP_ALLOCATE = 1'b0;
    localparam logic OP_RELEASE  = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_GRANTED  = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY    = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_RELEASED = 2'd2;

    typedef struct packed {
        logic              operation;
        logic              plane;
        logic [FIELD_W-1:0] slot_index;
    } item_t;

    typedef struct packed {
        logic [FIELD_W-1:0]  granted_slot;
        logic [STATUS_W-1:0] status;
    } result_t;

    typedef struct packed {
        logic              valid;
        logic [SLOT_W-1:0] slot;
    } link_t;

    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        link_t             wr_data;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
    } link_req_t;

endpackage
`default_nettype wire

// File: sv/dual_plane_slot_free_list_top.sv
// Top level of the dual-plane slot free list: head/tail control around the link store.
// Results: one result per item; allocate on a non-empty list and in-range release
// pass through a second state (link store read, second write), other items do not.
// Throughput: one item per cycle while busy is low; an item that touches the link store
// keeps busy high until its result is out. Reset: asynchronous, active low; afterwards
// the whole link store is swept with busy high. The receiver cannot stall results.
`timescale 1ns / 1ps
`default_nettype none
module dual_plane_slot_free_list_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  dpsfl_pkg::item_t   item,
    output logic               busy,
    output logic               done,
    output dpsfl_pkg::result_t result
);
    import dpsfl_pkg::*;

    typedef enum logic [3:0] {
        ST_INIT  = 4'b0001,
        ST_IDLE  = 4'b0010,
        ST_ALLOC = 4'b0100,
        ST_REL   = 4'b1000
    } state_t;

    state_t               state_reg;
    state_t               state_next;
    link_t                head_reg [2];
    link_t                head_next [2];
    link_t                tail_reg [2];
    link_t                tail_next [2];
    logic [COUNT_W-1:0]   fail_cnt_reg;
    logic [COUNT_W-1:0]   fail_cnt_next;
    logic                 plane_reg;
    logic                 plane_next;
    logic [SLOT_W-1:0]    slot_reg;
    logic [SLOT_W-1:0]    slot_next;
    logic                 done_reg;
    logic                 done_next;
    result_t              result_reg;
    result_t              result_next;
    link_req_t            req;
    link_t                rd_data;
    logic                 init_busy;
    link_t                head_cur;
    link_t                tail_cur;
    logic                 idx_ok;
    logic [SLOT_W-1:0]    idx;

    dpsfl_link_ram u_link_ram (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rd_data   (rd_data),
        .init_busy (init_busy)
    );

    assign head_cur = head_reg[item.plane];
    assign tail_cur = tail_reg[item.plane];
    assign idx_ok   = 32'(item.slot_index) < 32'(SLOT_COUNT);
    assign idx      = SLOT_W'(item.slot_index);

    always_comb
    begin
        state_next    = state_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        fail_cnt_next = fail_cnt_reg;
        plane_next    = plane_reg;
        slot_next     = slot_reg;
        done_next     = 1'b0;
        result_next   = result_reg;
        req           = '0;
        case (state_reg)
            ST_INIT:
            begin
                if (!init_busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    plane_next = item.plane;
                    if (item.operation == OP_ALLOCATE)
                    begin
                        if (!head_cur.valid)
                        begin
                            if (fail_cnt_reg != '1)
                            begin
                                fail_cnt_next = fail_cnt_reg + COUNT_W'(1);
                            end
                            done_next                = 1'b1;
                            result_next.granted_slot = '0;
                            result_next.status       = STATUS_EMPTY;
                        end
                        else
                        begin
                            req.rd_en  = 1'b1;
                            req.rd_addr = {item.plane, head_cur.slot};
                            slot_next  = head_cur.slot;
                            state_next = ST_ALLOC;
                        end
                    end
                    else if (idx_ok)
                    begin
                        if (tail_cur.valid)
                        begin
                            req.wr_en         = 1'b1;
                            req.wr_addr       = {item.plane, tail_cur.slot};
                            req.wr_data.valid = 1'b1;
                            req.wr_data.slot  = idx;
                        end
                        else
                        begin
                            head_next[item.plane].valid = 1'b1;
                            head_next[item.plane].slot  = idx;
                        end
                        tail_next[item.plane].valid = 1'b1;
                        tail_next[item.plane].slot  = idx;
                        slot_next  = idx;
                        state_next = ST_REL;
                    end
                    else
                    begin
                        done_next                = 1'b1;
                        result_next.granted_slot = '0;
                        result_next.status       = STATUS_RELEASED;
                    end
                end
            end
            ST_ALLOC:
            begin
                head_next[plane_reg] = rd_data;
                if (!rd_data.valid)
                begin
                    tail_next[plane_reg].valid = 1'b0;
                end
                req.wr_en                = 1'b1;
                req.wr_addr              = {plane_reg, slot_reg};
                req.wr_data              = '0;
                done_next                = 1'b1;
                result_next.granted_slot = FIELD_W'(slot_reg);
                result_next.status       = STATUS_GRANTED;
                state_next               = ST_IDLE;
            end
            ST_REL:
            begin
                req.wr_en                = 1'b1;
                req.wr_addr              = {plane_reg, slot_reg};
                req.wr_data              = '0;
                done_next                = 1'b1;
                result_next.granted_slot = '0;
                result_next.status       = STATUS_RELEASED;
                state_next               = ST_IDLE;
            end
            default:
            begin
                state_next = ST_INIT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_INIT;
            head_reg[0]  <= '{valid: 1'b1, slot: SLOT_W'(SLOT_COUNT - 1)};
            head_reg[1]  <= '{valid: 1'b1, slot: SLOT_W'(SLOT_COUNT - 1)};
            tail_reg[0]  <= '{valid: 1'b1, slot: '0};
            tail_reg[1]  <= '{valid: 1'b1, slot: '0};
            fail_cnt_reg <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            fail_cnt_reg <= fail_cnt_next;
            done_reg     <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        plane_reg  <= plane_next;
        slot_reg   <= slot_next;
        result_reg <= result_next;
    end

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

endmodule
`default_nettype wire

// File: sv/dpsfl_link_ram.sv
// Link store memory of both planes with its sweep after reset that links each slot to the one below.
`timescale 1ns / 1ps
`default_nettype none
module dpsfl_link_ram (
    input  logic                 clk,
    input  logic                 rst_n,
    input  dpsfl_pkg::link_req_t req,
    output dpsfl_pkg::link_t     rd_data,
    output logic                 init_busy
);
    import dpsfl_pkg::*;

    link_t             mem [0:LINK_DEPTH-1];
    link_t             rd_data_reg;
    logic [ADDR_W-1:0] init_cnt_reg;
    logic [ADDR_W-1:0] init_cnt_next;
    logic              init_busy_reg;
    logic              init_busy_next;
    logic [SLOT_W-1:0] init_slot;
    link_t             init_link;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    link_t             wr_data;

    assign init_slot = init_cnt_reg[SLOT_W-1:0];

    always_comb
    begin
        init_link = '0;
        if (init_slot != '0)
        begin
            init_link.valid = 1'b1;
            init_link.slot  = init_slot - SLOT_W'(1);
        end
    end

    always_comb
    begin
        init_cnt_next  = init_cnt_reg;
        init_busy_next = init_busy_reg;
        if (init_busy_reg)
        begin
            init_cnt_next = init_cnt_reg + ADDR_W'(1);
            if (&init_cnt_reg)
            begin
                init_busy_next = 1'b0;
            end
        end
    end

    assign wr_en   = init_busy_reg || req.wr_en;
    assign wr_addr = init_busy_reg ? init_cnt_reg : req.wr_addr;
    assign wr_data = init_busy_reg ? init_link : req.wr_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_cnt_reg  <= '0;
            init_busy_reg <= 1'b1;
        end
        else
        begin
            init_cnt_reg  <= init_cnt_next;
            init_busy_reg <= init_busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    assign rd_data   = rd_data_reg;
    assign init_busy = init_busy_reg;

endmodule
`default_nettype wire

// File: sv/dpsfl_checker.sv
// Port-level checks of the dual-plane slot free list, bound to its top level.
`timescale 1ns / 1ps
`default_nettype none
module dpsfl_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               start,
    input wire dpsfl_pkg::item_t   item,
    input wire logic               busy,
    input wire logic               done,
    input wire dpsfl_pkg::result_t result
);
    import dpsfl_pkg::*;

    logic accept;

    assign accept = start && !busy;

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept ##1 !done |=> done)
        else $error("item without a result within two cycles");

    a_no_stray_result: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(accept) || $past(accept, 2)))
        else $error("result without an accepted item");

    a_no_grant_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && (result.status != STATUS_GRANTED) |-> (result.granted_slot == '0))
        else $error("slot reported on a result that grants nothing");

    a_release_status: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (item.operation == OP_RELEASE) ##2 done
            |-> (result.status == STATUS_RELEASED))
        else $error("release item reported a wrong status");

endmodule

bind dual_plane_slot_free_list_top dpsfl_checker u_dpsfl_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .item   (item),
    .busy   (busy),
    .done   (done),
    .result (result)
);
`default_nettype wire
